[design/nmea_sentence_receiver_fix_detect_defines.svh]
// Assertion macros used by the top-level design file.
`ifndef NMEA_SENTENCE_RECEIVER_FIX_DETECT_DEFINES_SVH
`define NMEA_SENTENCE_RECEIVER_FIX_DETECT_DEFINES_SVH

`ifndef SYNTHESIS
`define NSR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define NSR_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define NSR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define NSR_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

[design/nsr_pkg.sv]
package nsr_pkg;

	localparam int MAX_LEN_DEFAULT = 95;
	localparam int LEN_W = 7;
	localparam int PREFIX_LEN = 12;
	localparam int STATUS_POS = 12;
	localparam int MODE_POS = 16;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_ONE = 8'h31;
	localparam logic [7:0] CH_TWO = 8'h32;

	typedef struct packed {
		logic done;
		logic ok;
		logic fix;
		logic [LEN_W-1:0] len;
		logic in_sentence;
	} res_t;

	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0: ch = "$";
			4'd1: ch = "P";
			4'd2: ch = "E";
			4'd3: ch = "R";
			4'd4: ch = "C";
			4'd5: ch = ",";
			4'd6: ch = "G";
			4'd7: ch = "P";
			4'd8: ch = "s";
			4'd9: ch = "t";
			4'd10: ch = "s";
			4'd11: ch = ",";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [3:0] v;
		v = 4'h0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
		end
		return v;
	endfunction

endpackage

[design/nsr_parser.sv]
module nsr_parser #(
	parameter int MAX_SENTENCE_LEN = nsr_pkg::MAX_LEN_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] rx_byte,
	output nsr_pkg::res_t res
);
	import nsr_pkg::*;

	localparam int CNT_W = $clog2(MAX_SENTENCE_LEN + 1);

	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_READ = 3'd1,
		PH_CKHI = 3'd2,
		PH_CKLO = 3'd3,
		PH_CR = 3'd4,
		PH_LF = 3'd5
	} phase_t;

	phase_t phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0] xor_q, xor_d;
	logic match_q, match_d;
	logic [7:0] status_q, status_d;
	logic [7:0] mode_q, mode_d;
	logic fix_q, fix_d;
	logic done_d, ok_d;
	logic [CNT_W+LEN_W-1:0] len_ext;

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		xor_d = xor_q;
		match_d = match_q;
		status_d = status_q;
		mode_d = mode_q;
		fix_d = fix_q;
		done_d = 1'b0;
		ok_d = 1'b0;

		if (cnt_q >= CNT_W'(MAX_SENTENCE_LEN)) begin
			phase_d = PH_WAIT;
		end else begin
			if (cnt_q < CNT_W'(PREFIX_LEN)) begin
				match_d = match_q && (rx_byte == prefix_char(cnt_q[3:0]));
			end
			if (cnt_q == CNT_W'(STATUS_POS)) begin
				status_d = rx_byte;
			end
			if (cnt_q == CNT_W'(MODE_POS)) begin
				mode_d = rx_byte;
			end
			cnt_d = cnt_q + CNT_W'(1);
		end

		if (rx_byte == CH_DOLLAR) begin
			phase_d = PH_READ;
			xor_d = 8'h00;
			cnt_d = CNT_W'(1);
			match_d = 1'b1;
		end else begin
			case (phase_d)
				PH_READ: begin
					if (rx_byte == CH_STAR) begin
						phase_d = PH_CKHI;
					end else begin
						xor_d = xor_q ^ rx_byte;
					end
				end
				PH_CKHI: begin
					xor_d = xor_q ^ {hex_digit(rx_byte), 4'h0};
					phase_d = PH_CKLO;
				end
				PH_CKLO: begin
					xor_d = xor_q ^ {4'h0, hex_digit(rx_byte)};
					phase_d = PH_CR;
				end
				PH_CR: begin
					phase_d = (rx_byte == CH_CR) ? PH_LF : PH_WAIT;
				end
				PH_LF: begin
					phase_d = PH_WAIT;
					if (rx_byte == CH_LF) begin
						done_d = 1'b1;
						ok_d = (xor_q == 8'h00);
						if (match_d && cnt_d > CNT_W'(PREFIX_LEN)) begin
							fix_d = (status_d == CH_ONE || status_d == CH_TWO) &&
								(mode_d == CH_TWO);
						end
					end
				end
				default: begin
					phase_d = PH_WAIT;
					cnt_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			cnt_q <= '0;
			xor_q <= 8'h00;
			match_q <= 1'b0;
			status_q <= 8'h00;
			mode_q <= 8'h00;
			fix_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			xor_q <= xor_d;
			match_q <= match_d;
			status_q <= status_d;
			mode_q <= mode_d;
			fix_q <= fix_d;
		end
	end

	assign len_ext = {{LEN_W{1'b0}}, cnt_d};

	assign res.done = done_d;
	assign res.ok = ok_d;
	assign res.fix = fix_d;
	assign res.len = len_ext[LEN_W-1:0];
	assign res.in_sentence = (phase_d != PH_WAIT);

endmodule

[design/nmea_sentence_receiver_fix_detect.sv]
// Frames NMEA sentences from a stream of received bytes and tracks the fix flag carried by
// the status sentence. One byte can be taken in every clock cycle while the output side
// keeps taking results, and each byte yields exactly one result; a result is presented once
// its byte has passed an input register and then the parser state update, whose outputs land
// in the result register. The parser state is updated once per byte, which sets the
// sustained rate of one byte per cycle while the output side keeps taking results.
module nmea_sentence_receiver_fix_detect #(
	parameter int MAX_SENTENCE_LEN = nsr_pkg::MAX_LEN_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic sentence_done,
	output logic checksum_ok,
	output logic fix_valid,
	output logic [nsr_pkg::LEN_W-1:0] sentence_length,
	output logic in_sentence
);
	import nsr_pkg::*;

	`include "nmea_sentence_receiver_fix_detect_defines.svh"

	logic valid_s1;
	logic [7:0] byte_s1;
	logic valid_s2;
	res_t res_s2;
	res_t res;
	logic adv;
	logic accept;

	assign adv = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept = in_valid && !in_stall;

	nsr_parser #(
		.MAX_SENTENCE_LEN(MAX_SENTENCE_LEN)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.rx_byte(byte_s1),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv);
			valid_s2 <= adv || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign sentence_done = res_s2.done;
	assign checksum_ok = res_s2.ok;
	assign fix_valid = res_s2.fix;
	assign sentence_length = res_s2.len;
	assign in_sentence = res_s2.in_sentence;

	// A completed sentence leaves the parser waiting for the next start character.
	`NSR_ASSERT_IMP(a_done_leaves_sentence, clk, arst_n, valid_s2 && res_s2.done, !res_s2.in_sentence, "sentence completed while still inside a sentence")
	`NSR_ASSERT_IMP(a_ok_only_when_done, clk, arst_n, valid_s2 && res_s2.ok, res_s2.done, "checksum status reported without a completed sentence")
	// A byte held in the input register is never dropped while the output stalls.
	`NSR_ASSERT_NXT(a_input_held, clk, arst_n, valid_s1 && !adv, valid_s1, "held input transaction was lost")

endmodule

[dv/nmea_sentence_receiver_fix_detect_tb.sv]
`timescale 1ns / 100ps

module nmea_sentence_receiver_fix_detect_tb;
	import nsr_pkg::*;

	localparam int MAX_LEN = MAX_LEN_DEFAULT;
	localparam int RANDOM_BYTES = 1650;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [8*PREFIX_LEN-1:0] STATUS_PREFIX = "$PERC,GPsts,";

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_SUM_HI,
		PH_SUM_LO,
		PH_WANT_CR,
		PH_WANT_LF
	} phase_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic sentence_done;
	logic checksum_ok;
	logic fix_valid;
	logic [LEN_W-1:0] sentence_length;
	logic in_sentence;

	phase_e frame_phase = PH_IDLE;
	int unsigned frame_count = 0;
	logic [7:0] frame_xor = 8'h00;
	logic prefix_ok = 1'b0;
	logic [7:0] status_byte = 8'h00;
	logic [7:0] mode_byte = 8'h00;
	logic fix_state = 1'b0;

	res_t predicted_results[$];
	logic [7:0] body_q[$];

	int mismatches = 0;
	int results_checked = 0;
	int sentences_seen = 0;
	int zero_residues = 0;
	int fixes_seen = 0;
	int bytes_sent = 0;
	int noise_sent = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;

	nmea_sentence_receiver_fix_detect dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sentence_done(sentence_done),
		.checksum_ok(checksum_ok),
		.fix_valid(fix_valid),
		.sentence_length(sentence_length),
		.in_sentence(in_sentence)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
		if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
		return 4'h0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return "0" + 8'(v);
		return ($urandom_range(0, 1) ? "a" : "A") + 8'(v) - 8'd10;
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(32, 126));
		end while (c == CH_DOLLAR || c == CH_STAR);
		return c;
	endfunction

	function automatic res_t frame_byte(input logic [7:0] c);
		res_t r;
		int unsigned idx;
		r = '0;
		if (frame_count >= MAX_LEN) begin
			frame_phase = PH_IDLE;
		end else begin
			idx = frame_count;
			if (idx < PREFIX_LEN) begin
				prefix_ok = prefix_ok && (c == STATUS_PREFIX[8*(PREFIX_LEN-1-idx) +: 8]);
			end
			if (idx == STATUS_POS) status_byte = c;
			if (idx == MODE_POS) mode_byte = c;
			frame_count = idx + 1;
		end
		if (c == CH_DOLLAR) begin
			frame_phase = PH_BODY;
			frame_xor = 8'h00;
			frame_count = 1;
			prefix_ok = 1'b1;
		end else begin
			case (frame_phase)
				PH_BODY: begin
					if (c == CH_STAR) frame_phase = PH_SUM_HI;
					else frame_xor ^= c;
				end
				PH_SUM_HI: begin
					frame_xor ^= {hex_value(c), 4'h0};
					frame_phase = PH_SUM_LO;
				end
				PH_SUM_LO: begin
					frame_xor ^= {4'h0, hex_value(c)};
					frame_phase = PH_WANT_CR;
				end
				PH_WANT_CR: begin
					frame_phase = (c == CH_CR) ? PH_WANT_LF : PH_IDLE;
				end
				PH_WANT_LF: begin
					frame_phase = PH_IDLE;
					if (c == CH_LF) begin
						r.done = 1'b1;
						r.ok = (frame_xor == 8'h00);
						if (prefix_ok && frame_count > PREFIX_LEN) begin
							fix_state = (status_byte == CH_ONE || status_byte == CH_TWO) &&
								(mode_byte == CH_TWO);
						end
					end
				end
				default: begin
					frame_phase = PH_IDLE;
					frame_count = 0;
				end
			endcase
		end
		r.fix = fix_state;
		r.len = LEN_W'(frame_count);
		r.in_sentence = (frame_phase != PH_IDLE);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : scoreboard_proc
		res_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predicted_results.push_back(frame_byte(rx_byte));
			end
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result with no transaction pending, expected none, actual %b%b%b %0d %b",
						$time, sentence_done, checksum_ok, fix_valid, sentence_length,
						in_sentence);
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					check_field("sentence_done", 8'(want.done), 8'(sentence_done));
					check_field("checksum_ok", 8'(want.ok), 8'(checksum_ok));
					check_field("fix_valid", 8'(want.fix), 8'(fix_valid));
					check_field("sentence_length", 8'(want.len), 8'(sentence_length));
					check_field("in_sentence", 8'(want.in_sentence), 8'(in_sentence));
					results_checked++;
					if (want.done) begin
						sentences_seen++;
						if (want.ok) zero_residues++;
						if (want.fix) fixes_seen++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!stall_on) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic load_body(input string s);
		body_q.delete();
		for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
	endtask

	task automatic send_sentence(input bit sum_good, input bit tail_good);
		logic [7:0] residue;
		residue = 8'h00;
		send_byte(CH_DOLLAR);
		foreach (body_q[i]) begin
			residue ^= body_q[i];
			send_byte(body_q[i]);
		end
		send_byte(CH_STAR);
		if (sum_good) begin
			send_byte(hex_char(residue[7:4]));
			send_byte(hex_char(residue[3:0]));
		end else begin
			send_byte(8'($urandom_range(0, 255)));
			send_byte(8'($urandom_range(0, 255)));
		end
		if (tail_good) begin
			send_byte(CH_CR);
			send_byte(CH_LF);
		end else if ($urandom_range(0, 1)) begin
			send_byte(CH_CR);
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic wait_for_results(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (predicted_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic test_idle_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_LF);
	endtask

	task automatic test_fix_sentences();
		load_body("PERC,GPsts,1,,,2");
		send_sentence(1'b1, 1'b1);
		load_body("PERC,GPsts,0");
		send_sentence(1'b1, 1'b1);
		wait_for_results(0);
	endtask

	task automatic test_malformed_sentences();
		send_text("$*00\r\n");
		send_text("$A*G1\r\n");
		send_text("$*00\rX");
		send_text("$*00Y");
		send_text("$AB$*00\r\n");
		send_text("$PERC,*00\r\n");
	endtask

	task automatic test_length_limit();
		body_q.delete();
		repeat (MAX_LEN - 6) body_q.push_back(text_char());
		send_sentence(1'b1, 1'b1);
		body_q.push_back(text_char());
		send_sentence(1'b1, 1'b1);
	endtask

	task automatic test_random_traffic();
		int kind;
		int tail;
		int r;
		while (bytes_sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 15) == 0) gaps_on = ~gaps_on;
			if ($urandom_range(0, 15) == 0) stall_on = ~stall_on;
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				load_body("PERC,GPsts,");
				if ($urandom_range(0, 9) == 0) body_q[$urandom_range(0, 10)] = text_char();
				r = $urandom_range(0, 99);
				tail = (r < 80) ? $urandom_range(5, 20) :
					(r < 92) ? $urandom_range(0, 4) : $urandom_range(70, 95);
				for (int j = 0; j < tail; j++) begin
					case (j)
						STATUS_POS - PREFIX_LEN: begin
							case ($urandom_range(0, 4))
								0: body_q.push_back("0");
								1: body_q.push_back(CH_ONE);
								2: body_q.push_back(CH_TWO);
								3: body_q.push_back("A");
								default: body_q.push_back(text_char());
							endcase
						end
						MODE_POS - PREFIX_LEN: begin
							case ($urandom_range(0, 3))
								0: body_q.push_back(CH_ONE);
								1, 2: body_q.push_back(CH_TWO);
								default: body_q.push_back(text_char());
							endcase
						end
						default: body_q.push_back(text_char());
					endcase
				end
				send_sentence($urandom_range(0, 9) != 0, $urandom_range(0, 11) != 0);
			end else if (kind < 75) begin
				load_body("GPGGA,");
				tail = ($urandom_range(0, 19) == 0) ? $urandom_range(85, 95) :
					$urandom_range(0, 40);
				repeat (tail) body_q.push_back(text_char());
				send_sentence($urandom_range(0, 9) != 0, $urandom_range(0, 11) != 0);
			end else if (kind < 88) begin
				tail = $urandom_range(1, 8);
				repeat (tail) send_byte(8'($urandom_range(0, 255)));
				noise_sent += tail;
			end else begin
				send_byte(CH_DOLLAR);
				repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1)) begin
					send_byte(CH_STAR);
					send_byte(hex_char(4'($urandom_range(0, 15))));
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_fix_sentences();
		test_malformed_sentences();
		test_length_limit();
		test_random_traffic();
		wait_for_results(SETTLE_CYCLES);
		if (predicted_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, predicted_results.size());
			mismatches++;
		end
		$display("Sent %0d bytes (%0d of them line noise) in %0d cycles; %0d results checked.",
			bytes_sent, noise_sent, cycle_count, results_checked);
		$display("%0d sentences completed, %0d with a zero residue, %0d leaving the fix set.",
			sentences_seen, zero_residues, fixes_seen);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[nmea_sentence_receiver_fix_detect.f]
+incdir+design
design/nsr_pkg.sv
design/nsr_parser.sv
design/nmea_sentence_receiver_fix_detect.sv
dv/nmea_sentence_receiver_fix_detect_tb.sv
